>>> rtl/imu_complementary_attitude_filter_defines.svh
// Assertion macros shared by the attitude filter RTL.
`ifndef IMU_COMPLEMENTARY_ATTITUDE_FILTER_DEFINES_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define ICAF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("icaf check failed");
// Next-cycle implication, disabled in reset.
`define ICAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("icaf check failed");
`else
`define ICAF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ICAF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/icaf_pkg.sv
// Constants, register indexes and the arctangent table of the attitude filter.
package icaf_pkg;

  // Parameter defaults
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 8;

  // Field and register widths
  localparam int IN_W       = 16;
  localparam int OUT_W      = 17;
  localparam int WEIGHT_W   = 17;
  localparam int GAIN_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN    = 2'd1;

  localparam logic [WEIGHT_W-1:0] BLEND_WEIGHT_RST = 17'd64225;
  localparam logic [GAIN_W-1:0]   GYRO_GAIN_RST    = 32'd131072;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE       = 17'h10000;

  // Datapath widths
  localparam int IN_SHIFT    = 8;   // accelerometer axes enter CORDIC times 256
  localparam int XY_W        = 27;
  localparam int ATAN_FRAC   = 16;  // angle accumulator in degrees times 2^16
  localparam int ATAN_W      = 22;
  localparam int ATAN_DEPTH  = 24;
  localparam int Z_W         = 26;
  localparam int CNT_W       = 5;
  localparam int ROOT_STEPS  = 24;
  localparam int ROOT_W      = 24;
  localparam int RAD_W       = 48;
  localparam int REM_W       = 26;
  localparam int SQ_W        = 32;
  localparam int MUL_A_W     = 18;
  localparam int MUL_B_W     = 34;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int PRED_W      = 34;
  localparam int GAIN_SHIFT  = 16;
  localparam int PRED_SHIFT  = 8;
  localparam int BLEND_SHIFT = 24;
  localparam int CLAMP_W     = 29;
  localparam int SUM_W       = CLAMP_W + BLEND_SHIFT;
  localparam int HALF_TURN   = 180;
  localparam int QUARTER_TURN = 90;

  // atan(2^-i) in degrees times 2^16, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [CNT_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/imu_complementary_attitude_filter.sv
// Roll and pitch complementary filter with a shared CORDIC, root and multiply datapath.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------------
//   in       | in_valid / in_ready    | accel_x, accel_y, accel_z, rate_x, rate_y
//   out      | out_valid / out_ready  | roll_angle, pitch_angle
//   cfg      | cfg_write              | cfg_index, cfg_data
//
// The first sample after reset loads the accelerometer angles directly and skips the blend.
// A blended sample runs the 24-step bit-serial square root, two vectoring passes through the
// single CORDIC stage and eight passes through the one 18x34 multiplier.
// in_ready is high only while the sequencer is idle; a finished result waits in the
// output register while the next sample is taken in. Reset is synchronous and clears
// the kept angles, the seeded flag and both configuration registers to their defaults.
`include "imu_complementary_attitude_filter_defines.svh"

module imu_complementary_attitude_filter #(
  parameter int CORDIC_STEPS    = icaf_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = icaf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [icaf_pkg::IN_W-1:0]      accel_x,
  input  logic signed [icaf_pkg::IN_W-1:0]      accel_y,
  input  logic signed [icaf_pkg::IN_W-1:0]      accel_z,
  input  logic signed [icaf_pkg::IN_W-1:0]      rate_x,
  input  logic signed [icaf_pkg::IN_W-1:0]      rate_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [icaf_pkg::OUT_W-1:0]     roll_angle,
  output logic signed [icaf_pkg::OUT_W-1:0]     pitch_angle,
  input  logic                                  cfg_write,
  input  logic [icaf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [icaf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int STORE_W = ANGLE_FRAC_BITS + 9;
  localparam int Z_SHIFT = icaf_pkg::ATAN_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [STORE_W-1:0] LIM =
    STORE_W'(icaf_pkg::HALF_TURN << ANGLE_FRAC_BITS);
  localparam logic signed [icaf_pkg::Z_W-1:0] Z_QUARTER =
    icaf_pkg::Z_W'(icaf_pkg::QUARTER_TURN << icaf_pkg::ATAN_FRAC);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_SQ_SUM,
    ST_ROOT,
    ST_VEC_INIT,
    ST_VEC_STEP,
    ST_VEC_END,
    ST_MUL_GAIN,
    ST_MUL_PRED,
    ST_MUL_ALPHA,
    ST_MUL_BETA,
    ST_BLEND_END,
    ST_LOAD_OUT
  } state_t;

  state_t state;

  // Configuration
  logic [icaf_pkg::WEIGHT_W-1:0] blend_weight;
  logic [icaf_pkg::GAIN_W-1:0]   gyro_gain;

  // Sample
  logic signed [icaf_pkg::IN_W-1:0] ax_q, ay_q, az_q, gx_q, gy_q;

  // Kept state
  logic signed [STORE_W-1:0] roll_store, pitch_store;
  logic                      seeded;
  logic signed [STORE_W-1:0] acc_roll, acc_pitch;
  logic                      axis;   // low for roll, high for pitch
  logic [icaf_pkg::CNT_W-1:0] cnt;

  // Square root
  logic [icaf_pkg::RAD_W-1:0]  rad;
  logic [icaf_pkg::REM_W-1:0]  rem;
  logic [icaf_pkg::ROOT_W-1:0] root;
  logic [icaf_pkg::REM_W+1:0]  rem_sh, trial, rem_diff;
  logic                        take;

  // CORDIC
  logic signed [icaf_pkg::XY_W-1:0] x, y, vx, vy, dx, dy;
  logic signed [icaf_pkg::Z_W-1:0]  z, z_step, z_rnd;
  logic signed [icaf_pkg::CLAMP_W-1:0] z_ang;

  // Multiplier and blend
  logic signed [icaf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [icaf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [icaf_pkg::PROD_W-1:0]  prod, acc, g_rnd;
  logic signed [icaf_pkg::PRED_W-1:0]  pred;
  logic signed [icaf_pkg::SUM_W-1:0]   sum_all, sum_rnd;
  logic signed [icaf_pkg::CLAMP_W-1:0] blend_ang;
  logic [icaf_pkg::WEIGHT_W-1:0]       alpha, beta;
  logic signed [STORE_W-1:0]           kept, accel_ang;

  function automatic logic signed [STORE_W-1:0] clamp_angle(
    input logic signed [icaf_pkg::CLAMP_W-1:0] a
  );
    logic signed [icaf_pkg::CLAMP_W-1:0] lim_w;
    lim_w = icaf_pkg::CLAMP_W'(LIM);
    if (a > lim_w) begin
      return LIM;
    end else if (a < -lim_w) begin
      return -LIM;
    end
    return a[STORE_W-1:0];
  endfunction

  assign in_ready = (state == ST_IDLE) && !rst;

  // Bit-serial square root, two radicand bits a step
  assign rem_sh   = {rem, rad[icaf_pkg::RAD_W-1 -: 2]};
  assign trial    = {2'b00, root, 2'b01};
  assign take     = (rem_sh >= trial);
  assign rem_diff = rem_sh - trial;

  // Vector seed with a quarter-turn pre-rotation for the left half plane
  always_comb begin
    logic signed [icaf_pkg::XY_W-1:0] sx, sy;
    if (!axis) begin
      sx = icaf_pkg::XY_W'(az_q) <<< icaf_pkg::IN_SHIFT;
      sy = icaf_pkg::XY_W'(ay_q) <<< icaf_pkg::IN_SHIFT;
    end else begin
      sx = icaf_pkg::XY_W'(root);
      sy = -(icaf_pkg::XY_W'(ax_q) <<< icaf_pkg::IN_SHIFT);
    end
    vx = sx;
    vy = sy;
    z_step = '0;
    if (sx < 0) begin
      if (sy >= 0) begin
        vx = sy;
        vy = -sx;
        z_step = Z_QUARTER;
      end else begin
        vx = -sy;
        vy = sx;
        z_step = -Z_QUARTER;
      end
    end
  end

  assign dx    = y >>> cnt;
  assign dy    = x >>> cnt;
  assign z_rnd = z + (icaf_pkg::Z_W'(1) <<< (Z_SHIFT - 1));
  assign z_ang = icaf_pkg::CLAMP_W'(z_rnd >>> Z_SHIFT);

  assign alpha     = (blend_weight > icaf_pkg::WEIGHT_ONE) ? icaf_pkg::WEIGHT_ONE
                                                          : blend_weight;
  assign beta      = icaf_pkg::WEIGHT_ONE - alpha;
  assign kept      = axis ? pitch_store : roll_store;
  assign accel_ang = axis ? acc_pitch : acc_roll;
  assign g_rnd     = prod + (icaf_pkg::PROD_W'(1) <<< (icaf_pkg::GAIN_SHIFT - 1));
  assign sum_all   = icaf_pkg::SUM_W'(acc) + icaf_pkg::SUM_W'(prod);
  assign sum_rnd   = sum_all + (icaf_pkg::SUM_W'(1) <<< (icaf_pkg::BLEND_SHIFT - 1));
  assign blend_ang = sum_rnd[icaf_pkg::SUM_W-1:icaf_pkg::BLEND_SHIFT];

  // Shared multiplier operands
  always_comb begin
    unique case (state)
      ST_SQ_A: begin
        mul_a = icaf_pkg::MUL_A_W'(ay_q);
        mul_b = icaf_pkg::MUL_B_W'(ay_q);
      end
      ST_SQ_B: begin
        mul_a = icaf_pkg::MUL_A_W'(az_q);
        mul_b = icaf_pkg::MUL_B_W'(az_q);
      end
      ST_MUL_GAIN: begin
        mul_a = axis ? icaf_pkg::MUL_A_W'(gy_q) : icaf_pkg::MUL_A_W'(gx_q);
        mul_b = icaf_pkg::MUL_B_W'(gyro_gain);
      end
      ST_MUL_ALPHA: begin
        mul_a = icaf_pkg::MUL_A_W'(alpha);
        mul_b = pred;
      end
      ST_MUL_BETA: begin
        mul_a = icaf_pkg::MUL_A_W'(beta);
        mul_b = icaf_pkg::MUL_B_W'(accel_ang) <<< icaf_pkg::PRED_SHIFT;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    logic signed [STORE_W-1:0] ang;
    ang  = clamp_angle(z_ang);
    prod <= mul_a * mul_b;
    if (rst) begin
      state        <= ST_IDLE;
      blend_weight <= icaf_pkg::BLEND_WEIGHT_RST;
      gyro_gain    <= icaf_pkg::GYRO_GAIN_RST;
      roll_store   <= '0;
      pitch_store  <= '0;
      seeded       <= 1'b0;
      out_valid    <= 1'b0;
      axis         <= 1'b0;
      cnt          <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          icaf_pkg::REG_BLEND_WEIGHT: blend_weight <= cfg_data[icaf_pkg::WEIGHT_W-1:0];
          icaf_pkg::REG_GYRO_GAIN:    gyro_gain    <= cfg_data[icaf_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end

      // Drop the beat once taken, unless a new one is loaded this cycle
      if (out_valid && out_ready && state != ST_LOAD_OUT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ax_q  <= accel_x;
            ay_q  <= accel_y;
            az_q  <= accel_z;
            gx_q  <= rate_x;
            gy_q  <= rate_y;
            state <= ST_SQ_A;
          end
        end
        ST_SQ_A: state <= ST_SQ_B;
        ST_SQ_B: begin
          acc   <= prod;
          state <= ST_SQ_SUM;
        end
        ST_SQ_SUM: begin
          rad   <= {sum_all[icaf_pkg::SQ_W-1:0], {(icaf_pkg::RAD_W - icaf_pkg::SQ_W){1'b0}}};
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          rad  <= rad << 2;
          rem  <= take ? rem_diff[icaf_pkg::REM_W-1:0] : rem_sh[icaf_pkg::REM_W-1:0];
          root <= {root[icaf_pkg::ROOT_W-2:0], take};
          if (cnt == icaf_pkg::CNT_W'(icaf_pkg::ROOT_STEPS - 1)) begin
            axis  <= 1'b0;
            state <= ST_VEC_INIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_VEC_INIT: begin
          x     <= vx;
          y     <= vy;
          z     <= z_step;
          cnt   <= '0;
          state <= ST_VEC_STEP;
        end
        ST_VEC_STEP: begin
          // Rotate toward the x axis; hold when already on it
          if (y > 0) begin
            x <= x + dx;
            y <= y - dy;
            z <= z + icaf_pkg::Z_W'(icaf_pkg::atan_q16(cnt));
          end else if (y < 0) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - icaf_pkg::Z_W'(icaf_pkg::atan_q16(cnt));
          end
          if (cnt == icaf_pkg::CNT_W'(CORDIC_STEPS - 1)) begin
            state <= ST_VEC_END;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_VEC_END: begin
          if (!axis) begin
            acc_roll <= ang;
            axis     <= 1'b1;
            state    <= ST_VEC_INIT;
          end else begin
            acc_pitch <= ang;
            if (!seeded) begin
              // First sample: load the accelerometer angles as they are
              roll_store  <= acc_roll;
              pitch_store <= ang;
              seeded      <= 1'b1;
              state       <= ST_LOAD_OUT;
            end else begin
              axis  <= 1'b0;
              state <= ST_MUL_GAIN;
            end
          end
        end
        ST_MUL_GAIN: state <= ST_MUL_PRED;
        ST_MUL_PRED: begin
          pred  <= (icaf_pkg::PRED_W'(kept) <<< icaf_pkg::PRED_SHIFT)
                 + g_rnd[icaf_pkg::GAIN_SHIFT +: icaf_pkg::PRED_W];
          state <= ST_MUL_ALPHA;
        end
        ST_MUL_ALPHA: state <= ST_MUL_BETA;
        ST_MUL_BETA: begin
          acc   <= prod;
          state <= ST_BLEND_END;
        end
        ST_BLEND_END: begin
          if (!axis) begin
            roll_store <= clamp_angle(blend_ang);
            axis       <= 1'b1;
            state      <= ST_MUL_GAIN;
          end else begin
            pitch_store <= clamp_angle(blend_ang);
            state       <= ST_LOAD_OUT;
          end
        end
        ST_LOAD_OUT: begin
          // Hold until the previous beat has left the output register
          if (!out_valid || out_ready) begin
            roll_angle  <= icaf_pkg::OUT_W'(roll_store);
            pitch_angle <= icaf_pkg::OUT_W'(pitch_store);
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ICAF_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `ICAF_ASSERT_IMPLY(a_result_from_sequencer, clk, rst, $rose(out_valid), $past(state == ST_LOAD_OUT))
  `ICAF_ASSERT_IMPLY(a_roll_in_range, clk, rst, seeded, (roll_store <= LIM) && (roll_store >= -LIM))
  `ICAF_ASSERT_NEXT(a_seeded_holds, clk, rst, seeded, seeded)

endmodule

>>> tb/tb_imu_complementary_attitude_filter.sv
// Self-checking testbench: roll and pitch filter against a cycle-free angle predictor.
`timescale 1ns / 100ps

module tb_imu_complementary_attitude_filter;

  localparam int STEPS      = icaf_pkg::CORDIC_STEPS_DEF;
  localparam int FRAC       = icaf_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int SEG_ITEMS  = 165;
  localparam int DRAIN_WAIT = 80;
  localparam int CYCLE_CAP  = 800000;
  localparam logic [icaf_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [icaf_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic signed [icaf_pkg::IN_W-1:0] ax, ay, az, gx, gy;
  } imu_beat_t;

  typedef struct packed {
    logic [icaf_pkg::OUT_W-1:0] roll, pitch;
  } attitude_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [icaf_pkg::IN_W-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic signed [icaf_pkg::IN_W-1:0] rate_x = '0, rate_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [icaf_pkg::OUT_W-1:0] roll_angle, pitch_angle;
  logic cfg_write = 1'b0;
  logic [icaf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [icaf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  imu_beat_t imu_pending [$];
  attitude_t attitude_expected [$];
  imu_beat_t next_beat;
  attitude_t got_attitude, want_attitude;

  // predictor state and its copy of the registers
  longint kept_roll, kept_pitch;
  bit angles_seeded;
  logic [icaf_pkg::WEIGHT_W-1:0] model_weight;
  logic [icaf_pkg::GAIN_W-1:0] model_gain;

  int send_idle_pct, recv_idle_pct;
  int mismatch_count = 0;
  int cycle_count = 0;

  imu_complementary_attitude_filter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .rate_x(rate_x), .rate_y(rate_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .roll_angle(roll_angle), .pitch_angle(pitch_angle),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint arctan_step(int i);
    case (i)
      0: return 2949120;   1: return 1740967;   2: return 919879;   3: return 466945;
      4: return 234379;    5: return 117304;    6: return 58666;    7: return 29335;
      8: return 14668;     9: return 7334;     10: return 3667;    11: return 1833;
      12: return 917;     13: return 458;      14: return 229;     15: return 115;
      16: return 57;      17: return 29;       18: return 14;      19: return 7;
      20: return 4;       21: return 2;        22: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint clamp_half_turn(longint a);
    longint lim;
    lim = longint'(icaf_pkg::HALF_TURN) <<< FRAC;
    if (a > lim) return lim;
    if (a < -lim) return -lim;
    return a;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, probe;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // vectoring atan2(y, x), result in angle units
  function automatic longint vector_angle(longint y_in, longint x_in);
    longint x, y, z, t, dx, dy;
    x = x_in;
    y = y_in;
    z = 0;
    // fold the left half-plane onto the right one first
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t;
        z = longint'(icaf_pkg::QUARTER_TURN) <<< 16;
      end else begin
        t = x; x = -y; y = t;
        z = -(longint'(icaf_pkg::QUARTER_TURN) <<< 16);
      end
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + arctan_step(i);
      end else if (y < 0) begin
        x = x - dx; y = y + dy; z = z - arctan_step(i);
      end
    end
    z = (z + (64'sd1 <<< (16 - FRAC - 1))) >>> (16 - FRAC);
    return clamp_half_turn(z);
  endfunction

  function automatic longint blend_angle(longint kept, longint rate, longint acc);
    longint alpha, gain, g, pred, sum;
    alpha = (model_weight > icaf_pkg::WEIGHT_ONE) ? 65536 : model_weight;
    gain = model_gain;
    g = (rate * gain + (64'sd1 <<< 15)) >>> 16;
    pred = kept * 256 + g;
    sum = alpha * pred + (65536 - alpha) * (acc * 256);
    return clamp_half_turn((sum + (64'sd1 <<< 23)) >>> 24);
  endfunction

  task automatic predict_attitude(input imu_beat_t b);
    longint ax, ay, az, gx, gy, mag, acc_roll, acc_pitch;
    attitude_t e;
    ax = b.ax; ay = b.ay; az = b.az; gx = b.gx; gy = b.gy;
    mag = root_floor((ay * ay + az * az) <<< 16);
    acc_roll = vector_angle(ay * 256, az * 256);
    acc_pitch = vector_angle(-ax * 256, mag);
    if (!angles_seeded) begin
      kept_roll = acc_roll;
      kept_pitch = acc_pitch;
      angles_seeded = 1'b1;
    end else begin
      kept_roll = blend_angle(kept_roll, gx, acc_roll);
      kept_pitch = blend_angle(kept_pitch, gy, acc_pitch);
    end
    e.roll = kept_roll[icaf_pkg::OUT_W-1:0];
    e.pitch = kept_pitch[icaf_pkg::OUT_W-1:0];
    attitude_expected.push_back(e);
  endtask

  // driver: hold the beat until accepted, then maybe idle before the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        predict_attitude('{accel_x, accel_y, accel_z, rate_x, rate_y});
      if (!in_valid || in_ready) begin
        if (imu_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_beat = imu_pending.pop_front();
          accel_x <= next_beat.ax;
          accel_y <= next_beat.ay;
          accel_z <= next_beat.az;
          rate_x <= next_beat.gx;
          rate_y <= next_beat.gy;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_attitude.roll = roll_angle;
        got_attitude.pitch = pitch_angle;
        if (attitude_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat: roll %0d pitch %0d",
                     roll_angle, pitch_angle);
        end else begin
          want_attitude = attitude_expected.pop_front();
          if (got_attitude.roll !== want_attitude.roll ||
              got_attitude.pitch !== want_attitude.pitch) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: roll exp %0d got %0d, pitch exp %0d got %0d",
                       $signed(want_attitude.roll), roll_angle,
                       $signed(want_attitude.pitch), pitch_angle);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("[imu_complementary_attitude_filter] ERROR");
      $finish;
    end
  end

  task automatic push_beat(input int ax, ay, az, gx, gy);
    imu_beat_t b;
    b.ax = ax[icaf_pkg::IN_W-1:0]; b.ay = ay[icaf_pkg::IN_W-1:0];
    b.az = az[icaf_pkg::IN_W-1:0];
    b.gx = gx[icaf_pkg::IN_W-1:0]; b.gy = gy[icaf_pkg::IN_W-1:0];
    imu_pending.push_back(b);
  endtask

  function automatic int near(int centre, int spread);
    return centre - spread + int'($urandom_range(2 * spread));
  endfunction

  task automatic push_random_beat();
    int kind, ax, ay, az, gx, gy;
    kind = $urandom_range(15);
    ax = int'($urandom_range(65535)) - 32768;
    ay = int'($urandom_range(65535)) - 32768;
    az = int'($urandom_range(65535)) - 32768;
    gx = int'($urandom_range(65535)) - 32768;
    gy = int'($urandom_range(65535)) - 32768;
    case (kind)
      0: begin ax = 0; ay = 0; az = 0; end
      1: begin ay = 0; az = 0; end
      2: begin ay = 0; az = -int'($urandom_range(32768)); end
      3: begin ax = near(0, 4); ay = near(0, 4); az = near(0, 4); end
      4, 5, 6, 7, 8: begin
        // roughly level sensor with modest motion
        ax = near(0, 8000); ay = near(0, 8000); az = near(16384, 6000);
        gx = near(0, 2000); gy = near(0, 2000);
      end
      default: ;
    endcase
    push_beat(ax, ay, az, gx, gy);
  endtask

  task automatic wait_drained();
    while (imu_pending.size() > 0 || in_valid || attitude_expected.size() > 0)
      @(posedge clk);
  endtask

  task automatic apply_settings(input logic [icaf_pkg::CFG_DATA_W-1:0] w, g,
                                input logic [icaf_pkg::CFG_IDX_W-1:0] spare);
    cfg_write <= 1'b1;
    cfg_index <= icaf_pkg::REG_BLEND_WEIGHT;
    cfg_data <= w;
    model_weight = w[icaf_pkg::WEIGHT_W-1:0];
    @(posedge clk);
    cfg_index <= icaf_pkg::REG_GYRO_GAIN;
    cfg_data <= g;
    model_gain = g;
    @(posedge clk);
    // an index past the register file must leave both registers alone
    cfg_index <= spare;
    cfg_data <= $urandom();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [icaf_pkg::CFG_DATA_W-1:0] w, g;
    kept_roll = 0;
    kept_pitch = 0;
    angles_seeded = 1'b0;
    model_weight = icaf_pkg::BLEND_WEIGHT_RST;
    model_gain = icaf_pkg::GYRO_GAIN_RST;
    send_idle_pct = 37;
    recv_idle_pct = 65;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: zero vectors, left half-plane, full-scale axes and rates
    push_beat(0, 0, 0, 0, 0);
    push_beat(1000, 0, 0, 32767, -32768);
    push_beat(0, 0, -16384, 0, 0);
    push_beat(-32768, 0, -32768, -32768, 32767);
    push_beat(32767, 32767, 32767, 32767, 32767);
    push_beat(-32768, -32768, -32768, -32768, -32768);
    push_beat(0, 32767, 0, 100, -100);
    push_beat(0, -32768, 0, -100, 100);
    push_beat(0, 1, -1, 0, 0);
    push_beat(0, -1, -1, 0, 0);
    push_beat(32767, 0, 0, 0, 0);
    push_beat(-32768, 0, 0, 0, 0);
    push_beat(1, 1, 1, 1, 1);
    push_beat(0, 0, 16384, 32767, -32768);
    push_beat(0, 0, 16384, -32768, 32767);
    push_beat(0, -1, 0, 0, 0);
    push_beat(-1, 0, -1, 1, -1);
    push_beat(0, 0, 0, 32767, 32767);
    push_beat(0, 32767, -32768, 0, 0);
    push_beat(0, -32768, -32768, 0, 0);
    wait_drained();

    for (int seg = 0; seg < 6; seg++) begin
      if (seg < 2) begin
        send_idle_pct = 37; recv_idle_pct = 65;
      end else if (seg < 4) begin
        send_idle_pct = 65; recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      case (seg)
        0: begin w = 32'd0; g = 32'd0; end
        1: begin w = 32'd65536; g = 32'hFFFF_FFFF; end
        2: begin w = 32'hFFFF_FFFF; g = $urandom(); end
        3: begin w = $urandom_range(65536); g = $urandom_range(32'h40_0000); end
        4: begin w = 32'd65535; g = $urandom_range(32'h10_0000); end
        default: begin w = 32'd32768; g = icaf_pkg::GYRO_GAIN_RST; end
      endcase
      apply_settings(w, g, (seg % 2 == 0) ? REG_SPARE_LO : REG_SPARE_HI);
      repeat (SEG_ITEMS) push_random_beat();
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && attitude_expected.size() == 0)
      $display("[imu_complementary_attitude_filter] OK");
    else
      $display("[imu_complementary_attitude_filter] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/icaf_pkg.sv
rtl/imu_complementary_attitude_filter.sv
tb/tb_imu_complementary_attitude_filter.sv
